>>> rtl/motion_adaptive_ranging_scheduler_macros.svh
// assertion macros for the motion adaptive ranging scheduler
// used by the top level only; expects clk and arst_n in scope
`ifndef MOTION_ADAPTIVE_RANGING_SCHEDULER_MACROS_SVH
`define MOTION_ADAPTIVE_RANGING_SCHEDULER_MACROS_SVH

// same-cycle implication, checked out of reset
`define MARS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// next-cycle implication, checked out of reset
`define MARS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

>>> rtl/mars_pkg.sv
// shared types and constants of the motion adaptive ranging scheduler
// no dependencies
package mars_pkg;

	// input kinds
	localparam logic [2:0] KIND_LOAD     = 3'd0;
	localparam logic [2:0] KIND_MOTION   = 3'd1;
	localparam logic [2:0] KIND_SETTLE   = 3'd2;
	localparam logic [2:0] KIND_TICK     = 3'd3;
	localparam logic [2:0] KIND_EXCHANGE = 3'd4;

	// exchange outcomes
	localparam logic [1:0] OUT_SUCCESS  = 2'd0;
	localparam logic [1:0] OUT_MISS_PRE = 2'd1;

	// configuration register indexes
	localparam logic [2:0] REG_FAST  = 3'd0;
	localparam logic [2:0] REG_SLOW  = 3'd1;
	localparam logic [2:0] REG_HOLD  = 3'd2;
	localparam logic [2:0] REG_COUNT = 3'd3;
	localparam logic [2:0] REG_CAP   = 3'd4;
	localparam logic [2:0] REG_DRAIN = 3'd5;

	// register reset values and floors
	localparam logic [31:0] FAST_RESET  = 32'd1000;
	localparam logic [31:0] SLOW_RESET  = 32'd60000;
	localparam logic [31:0] HOLD_RESET  = 32'd30000;
	localparam logic [4:0]  COUNT_RESET = 5'd1;
	localparam logic [31:0] CAP_RESET   = 32'd230000000;
	localparam logic [31:0] DRAIN_RESET = 32'd100;
	localparam logic [31:0] FAST_MIN    = 32'd500;
	localparam logic [31:0] SLOW_MIN    = 32'd1000;

	// results per tick and counter ceilings
	localparam logic [4:0]  RESULT_LIMIT = 5'd16;
	localparam logic [15:0] MISS_MAX     = 16'hFFFF;

	// battery model
	localparam logic [11:0] MV_EMPTY     = 12'd2000;
	localparam logic [12:0] MV_BASE_LOW  = 13'd3000;
	localparam logic [12:0] MV_BASE_HIGH = 13'd6250;
	localparam logic [12:0] MUL_LOW      = 13'd375;
	localparam logic [12:0] MUL_HIGH     = 13'd4250;
	localparam logic [3:0]  DIV_STEPS    = 4'd13;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_NONE,
		ST_LK_RD,
		ST_LK_CMP,
		ST_ENT_UPD,
		ST_BATT,
		ST_TK_RD,
		ST_TK_EVAL,
		ST_TK_END
	} mars_state_t;

	typedef enum logic [1:0] {
		BT_IDLE,
		BT_CHK,
		BT_DIV,
		BT_FIN
	} mars_bstate_t;

	// per-entry record held in the state memory
	typedef struct packed {
		logic [31:0] served_time;
		logic [31:0] motion_end;
		logic [31:0] wake;
		logic [15:0] miss;
		logic [31:0] charge;
	} mars_ent_t;

	// one result word
	typedef struct packed {
		logic        found;
		logic [3:0]  slot;
		logic [15:0] identity;
		logic        moving;
		logic        woke;
		logic [11:0] battery_mv;
		logic [15:0] miss_count;
		logic        last;
	} mars_res_t;

	// inside the hold window: end ahead of now by less than half the clock range
	function automatic logic is_moving(input logic vld, input logic [31:0] end_t,
		input logic [31:0] now);
		logic [31:0] d;
		begin
			d = end_t - now;
			is_moving = vld && (d != 32'd0) && !d[31];
		end
	endfunction

endpackage

>>> rtl/motion_adaptive_ranging_scheduler.sv
// load writes one identity; motion/settle scan the entries in use; exchange adds the voltage computation
// tick: scans the entries in use; one result word per due entry (at most 16), or one not-found word, strobed once
// one item at a time: set by the sequential scan of the identity and state memories
// reset: registers to defaults, all per-entry state reads as zero; identities undefined
// results cannot be stalled; busy stays high until the last word has been shown
module motion_adaptive_ranging_scheduler #(
	parameter int MAX_IDENTITIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [31:0] now_ms,
	input  logic [15:0] tag_address,
	input  logic [3:0]  slot_index,
	input  logic [1:0]  outcome,
	output logic        result_valid,
	output logic        found,
	output logic [3:0]  slot,
	output logic [15:0] identity,
	output logic        moving,
	output logic        woke,
	output logic [11:0] battery_mv,
	output logic [15:0] miss_count,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IW = (MAX_IDENTITIES > 1) ? $clog2(MAX_IDENTITIES) : 1;
	localparam int CW = $clog2(MAX_IDENTITIES + 1);

	mars_pkg::mars_state_t st_q, st_d;

	// configuration
	logic [31:0] fast_q, slow_q, hold_q, cap_q, drain_q;
	logic [4:0]  cnt_q;

	// latched item
	logic [2:0]  kind_q;
	logic [31:0] now_q;
	logic [15:0] addr_q;
	logic [3:0]  sidx_q;
	logic [1:0]  outcome_q;

	// memories and per-entry flags
	logic [15:0]         id_mem [MAX_IDENTITIES];
	mars_pkg::mars_ent_t ent_mem [MAX_IDENTITIES];
	logic [15:0]         id_rd_q;
	mars_pkg::mars_ent_t ent_rd_q;
	logic [MAX_IDENTITIES-1:0] ent_v_q, srv_v_q, mot_v_q;

	// scan control
	logic [CW-1:0] scan_q;
	logic [IW-1:0] hit_q;
	logic [4:0]    kcnt_q;
	mars_pkg::mars_res_t pend_q, res_q, res_d;
	logic          pend_v_q, res_v_q;
	logic          xm_mov_q;
	logic [15:0]   xm_miss_q;

	logic          accept;
	logic [CW-1:0] lim;
	logic [IW-1:0] scan_ix, cur_ix, sidx_ix;
	logic          sidx_ok;
	logic          id_we, id_re, ent_re, ent_we, emit, batt_go, scan_inc, tk_due;
	mars_pkg::mars_ent_t ent_cur, ent_new;
	logic          cur_mov, was_mov, mov_after, due;
	logic [31:0]   period;
	logic [32:0]   ch_sum;
	logic [31:0]   ch_new;
	logic [15:0]   miss_out, miss_new;
	mars_pkg::mars_res_t tick_res;
	logic          batt_done;
	logic [11:0]   batt_mv;

	assign busy      = (st_q != mars_pkg::ST_IDLE) || res_v_q;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// entries in use
	always_comb begin
		if (32'(cnt_q) < 32'(MAX_IDENTITIES)) lim = CW'(cnt_q);
		else lim = CW'(MAX_IDENTITIES);
	end

	assign scan_ix = scan_q[IW-1:0];
	assign cur_ix  = (st_q == mars_pkg::ST_TK_EVAL) ? scan_ix : hit_q;
	assign sidx_ix = IW'(sidx_q);
	assign sidx_ok = 32'(sidx_q) < 32'(MAX_IDENTITIES);

	// current entry, zero until first written
	assign ent_cur = ent_v_q[cur_ix] ? ent_rd_q : '0;
	assign cur_mov = mars_pkg::is_moving(mot_v_q[cur_ix], ent_cur.motion_end, now_q);
	assign was_mov = cur_mov;
	assign mov_after = mars_pkg::is_moving(1'b1, now_q + hold_q, now_q);
	assign period  = cur_mov ? fast_q : slow_q;
	assign due     = !srv_v_q[cur_ix] || ((now_q - ent_cur.served_time) >= period);

	// exchange billing and miss counting
	assign ch_sum = {1'b0, ent_cur.charge} + {1'b0, drain_q};
	always_comb begin
		ch_new = ent_cur.charge;
		if (outcome_q != mars_pkg::OUT_MISS_PRE) ch_new = ch_sum[32] ? 32'hFFFF_FFFF : ch_sum[31:0];
		if (outcome_q == mars_pkg::OUT_SUCCESS) begin
			miss_new = 16'd0;
			miss_out = ent_cur.miss;
		end else begin
			miss_new = (ent_cur.miss == mars_pkg::MISS_MAX) ? mars_pkg::MISS_MAX
				: ent_cur.miss + 16'd1;
			miss_out = miss_new;
		end
	end

	// entry write-back value
	always_comb begin
		ent_new = ent_cur;
		if (st_q == mars_pkg::ST_TK_EVAL) begin
			ent_new.served_time = now_q;
		end else begin
			case (kind_q)
				mars_pkg::KIND_MOTION: begin
					ent_new.motion_end  = now_q + hold_q;
					ent_new.wake        = ent_cur.wake + {31'd0, !was_mov};
					ent_new.served_time = 32'd0;
				end
				mars_pkg::KIND_SETTLE: begin
					ent_new.motion_end  = 32'd0;
					ent_new.served_time = 32'd0;
				end
				mars_pkg::KIND_EXCHANGE: begin
					ent_new.charge = ch_new;
					ent_new.miss   = miss_new;
				end
				default: ;
			endcase
		end
	end

	// result word of a due entry
	always_comb begin
		tick_res          = '0;
		tick_res.found    = 1'b1;
		tick_res.slot     = 4'(scan_ix);
		tick_res.identity = id_rd_q;
		tick_res.moving   = cur_mov;
	end

	// next state and strobes
	always_comb begin
		st_d     = st_q;
		id_we    = 1'b0;
		id_re    = 1'b0;
		ent_re   = 1'b0;
		ent_we   = 1'b0;
		emit     = 1'b0;
		batt_go  = 1'b0;
		scan_inc = 1'b0;
		tk_due   = 1'b0;
		res_d    = '0;
		res_d.last = 1'b1;
		case (st_q)
			mars_pkg::ST_IDLE: begin
				if (accept) begin
					case (kind)
						mars_pkg::KIND_LOAD:     st_d = mars_pkg::ST_LOAD;
						mars_pkg::KIND_MOTION,
						mars_pkg::KIND_SETTLE,
						mars_pkg::KIND_EXCHANGE: st_d = mars_pkg::ST_LK_RD;
						mars_pkg::KIND_TICK:     st_d = mars_pkg::ST_TK_RD;
						default:                 st_d = mars_pkg::ST_NONE;
					endcase
				end
			end
			mars_pkg::ST_LOAD: begin
				emit = 1'b1;
				if (sidx_ok) begin
					id_we          = 1'b1;
					res_d.found    = 1'b1;
					res_d.slot     = sidx_q;
					res_d.identity = addr_q;
				end
				st_d = mars_pkg::ST_IDLE;
			end
			mars_pkg::ST_NONE: begin
				emit = 1'b1;
				st_d = mars_pkg::ST_IDLE;
			end
			mars_pkg::ST_LK_RD: begin
				if (scan_q == lim) begin
					st_d = mars_pkg::ST_NONE;
				end else begin
					id_re = 1'b1;
					st_d  = mars_pkg::ST_LK_CMP;
				end
			end
			mars_pkg::ST_LK_CMP: begin
				if (id_rd_q == addr_q) begin
					ent_re = 1'b1;
					st_d   = mars_pkg::ST_ENT_UPD;
				end else begin
					scan_inc = 1'b1;
					st_d     = mars_pkg::ST_LK_RD;
				end
			end
			mars_pkg::ST_ENT_UPD: begin
				ent_we         = 1'b1;
				res_d.found    = 1'b1;
				res_d.slot     = 4'(hit_q);
				res_d.identity = id_rd_q;
				if (kind_q == mars_pkg::KIND_EXCHANGE) begin
					batt_go = 1'b1;
					st_d    = mars_pkg::ST_BATT;
				end else begin
					emit = 1'b1;
					if (kind_q == mars_pkg::KIND_MOTION) begin
						res_d.moving = mov_after;
						res_d.woke   = !was_mov;
					end
					st_d = mars_pkg::ST_IDLE;
				end
			end
			mars_pkg::ST_BATT: begin
				if (batt_done) begin
					emit             = 1'b1;
					res_d.found      = 1'b1;
					res_d.slot       = 4'(hit_q);
					res_d.identity   = id_rd_q;
					res_d.moving     = xm_mov_q;
					res_d.battery_mv = batt_mv;
					res_d.miss_count = xm_miss_q;
					st_d             = mars_pkg::ST_IDLE;
				end
			end
			mars_pkg::ST_TK_RD: begin
				if ((scan_q == lim) || (kcnt_q == mars_pkg::RESULT_LIMIT)) begin
					st_d = mars_pkg::ST_TK_END;
				end else begin
					id_re  = 1'b1;
					ent_re = 1'b1;
					st_d   = mars_pkg::ST_TK_EVAL;
				end
			end
			mars_pkg::ST_TK_EVAL: begin
				scan_inc = 1'b1;
				if (due) begin
					tk_due = 1'b1;
					ent_we = 1'b1;
					if (pend_v_q) begin
						emit       = 1'b1;
						res_d      = pend_q;
						res_d.last = 1'b0;
					end
				end
				st_d = mars_pkg::ST_TK_RD;
			end
			mars_pkg::ST_TK_END: begin
				emit = 1'b1;
				if (pend_v_q) begin
					res_d      = pend_q;
					res_d.last = 1'b1;
				end
				st_d = mars_pkg::ST_IDLE;
			end
			default: st_d = mars_pkg::ST_IDLE;
		endcase
	end

	// control registers, configuration and per-entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= mars_pkg::ST_IDLE;
			res_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
			scan_q   <= '0;
			kcnt_q   <= 5'd0;
			ent_v_q  <= '0;
			srv_v_q  <= '0;
			mot_v_q  <= '0;
			fast_q   <= mars_pkg::FAST_RESET;
			slow_q   <= mars_pkg::SLOW_RESET;
			hold_q   <= mars_pkg::HOLD_RESET;
			cnt_q    <= mars_pkg::COUNT_RESET;
			cap_q    <= mars_pkg::CAP_RESET;
			drain_q  <= mars_pkg::DRAIN_RESET;
		end else begin
			st_q    <= st_d;
			res_v_q <= emit;
			if (accept) begin
				scan_q   <= '0;
				kcnt_q   <= 5'd0;
				pend_v_q <= 1'b0;
			end else if (scan_inc) begin
				scan_q <= scan_q + CW'(1);
			end
			if (tk_due) begin
				pend_v_q         <= 1'b1;
				kcnt_q           <= kcnt_q + 5'd1;
				srv_v_q[scan_ix] <= 1'b1;
				ent_v_q[scan_ix] <= 1'b1;
			end
			if (st_q == mars_pkg::ST_ENT_UPD) begin
				ent_v_q[hit_q] <= 1'b1;
				case (kind_q)
					mars_pkg::KIND_MOTION: begin
						mot_v_q[hit_q] <= 1'b1;
						srv_v_q[hit_q] <= 1'b0;
					end
					mars_pkg::KIND_SETTLE: begin
						mot_v_q[hit_q] <= 1'b0;
						srv_v_q[hit_q] <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mars_pkg::REG_FAST:  fast_q  <= (cfg_data < mars_pkg::FAST_MIN)
						? mars_pkg::FAST_MIN : cfg_data;
					mars_pkg::REG_SLOW:  slow_q  <= (cfg_data < mars_pkg::SLOW_MIN)
						? mars_pkg::SLOW_MIN : cfg_data;
					mars_pkg::REG_HOLD:  hold_q  <= cfg_data;
					mars_pkg::REG_COUNT: cnt_q   <= cfg_data[4:0];
					mars_pkg::REG_CAP:   cap_q   <= cfg_data;
					mars_pkg::REG_DRAIN: drain_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// item, result and scan payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= kind;
			now_q     <= now_ms;
			addr_q    <= tag_address;
			sidx_q    <= slot_index;
			outcome_q <= outcome;
		end
		if (emit) res_q <= res_d;
		if (tk_due) pend_q <= tick_res;
		if ((st_q == mars_pkg::ST_LK_CMP) && ent_re) hit_q <= scan_ix;
		if (st_q == mars_pkg::ST_ENT_UPD) begin
			xm_mov_q  <= cur_mov;
			xm_miss_q <= miss_out;
		end
	end

	// identity and entry-state memories
	always_ff @(posedge clk) begin
		if (id_we) id_mem[sidx_ix] <= addr_q;
		if (id_re) id_rd_q <= id_mem[scan_ix];
		if (ent_we) ent_mem[cur_ix] <= ent_new;
		if (ent_re) ent_rd_q <= ent_mem[scan_ix];
	end

	mars_batt u_batt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (batt_go),
		.charge   (ch_new),
		.capacity (cap_q),
		.done     (batt_done),
		.mv       (batt_mv)
	);

	assign result_valid = res_v_q;
	assign found        = res_q.found;
	assign slot         = res_q.slot;
	assign identity     = res_q.identity;
	assign moving       = res_q.moving;
	assign woke         = res_q.woke;
	assign battery_mv   = res_q.battery_mv;
	assign miss_count   = res_q.miss_count;
	assign last         = res_q.last;

	// checks
`include "motion_adaptive_ranging_scheduler_macros.svh"
	`MARS_ASSERT_NOW(a_miss_is_last, result_valid && !found, last)
	`MARS_ASSERT_NEXT(a_quiet_after_last, result_valid && last, !result_valid)
	`MARS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)

endmodule

>>> rtl/mars_batt.sv
// battery voltage unit: piecewise model with a bit-serial ceiling divider
// depends on mars_pkg
module mars_batt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] charge,
	input  logic [31:0] capacity,
	output logic        done,
	output logic [11:0] mv
);

	mars_pkg::mars_bstate_t st_q, st_d;
	logic [31:0] c_q;
	logic [31:0] cap_q;
	logic [44:0] rem_q;
	logic [44:0] den_q;
	logic [12:0] q_q;
	logic [12:0] base_q;
	logic [3:0]  step_q;
	logic        done_q;
	logic [11:0] mv_q;
	logic        empty;
	logic        low;
	logic [34:0] five_c;
	logic [34:0] four_cap;
	logic [32:0] den_base;
	logic [12:0] q_ceil;

	// region select
	assign empty    = c_q >= cap_q;
	assign five_c   = ({3'b000, c_q} << 2) + {3'b000, c_q};
	assign four_cap = {1'b0, cap_q, 2'b00};
	assign low      = five_c < four_cap;
	assign den_base = low ? {cap_q, 1'b0} : {1'b0, cap_q};
	assign q_ceil   = q_q + {12'd0, (rem_q != 45'd0)};

	// sequencer
	always_comb begin
		st_d = st_q;
		case (st_q)
			mars_pkg::BT_IDLE: if (go) st_d = mars_pkg::BT_CHK;
			mars_pkg::BT_CHK:  st_d = empty ? mars_pkg::BT_IDLE : mars_pkg::BT_DIV;
			mars_pkg::BT_DIV:  if (step_q == mars_pkg::DIV_STEPS - 4'd1) st_d = mars_pkg::BT_FIN;
			mars_pkg::BT_FIN:  st_d = mars_pkg::BT_IDLE;
			default:           st_d = mars_pkg::BT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= mars_pkg::BT_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= ((st_q == mars_pkg::BT_CHK) && empty) || (st_q == mars_pkg::BT_FIN);
		end
	end

	// datapath: constant multiply, then one quotient bit a cycle
	always_ff @(posedge clk) begin
		case (st_q)
			mars_pkg::BT_IDLE: begin
				c_q   <= charge;
				cap_q <= capacity;
			end
			mars_pkg::BT_CHK: begin
				rem_q  <= 45'(c_q) * 45'(low ? mars_pkg::MUL_LOW : mars_pkg::MUL_HIGH);
				den_q  <= {den_base, 12'd0};
				base_q <= low ? mars_pkg::MV_BASE_LOW : mars_pkg::MV_BASE_HIGH;
				q_q    <= 13'd0;
				step_q <= 4'd0;
				mv_q   <= mars_pkg::MV_EMPTY;
			end
			mars_pkg::BT_DIV: begin
				if (rem_q >= den_q) begin
					rem_q <= rem_q - den_q;
					q_q   <= {q_q[11:0], 1'b1};
				end else begin
					q_q <= {q_q[11:0], 1'b0};
				end
				den_q  <= den_q >> 1;
				step_q <= step_q + 4'd1;
			end
			mars_pkg::BT_FIN: mv_q <= 12'(base_q - q_ceil);
			default: ;
		endcase
	end

	assign done = done_q;
	assign mv   = mv_q;

endmodule

>>> test/motion_adaptive_ranging_scheduler_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the motion adaptive ranging scheduler
// depends on mars_pkg and the motion_adaptive_ranging_scheduler top level
module motion_adaptive_ranging_scheduler_test;

	// codes not named in the package
	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
	localparam logic [1:0] OUT_MISS_POST    = 2'd2;
	localparam logic [1:0] OUT_MISS_ODD     = 2'd3;
	localparam int ENTRIES    = 16;
	localparam int SETTLE_CYC = 80;
	localparam int DOG_LIMIT  = 5000;

	typedef struct {
		logic [2:0]  k;
		logic [31:0] t;
		logic [15:0] a;
		logic [3:0]  s;
		logic [1:0]  o;
		bit          typed;
		mars_pkg::mars_res_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] kind = '0;
	logic [31:0] now_ms = '0;
	logic [15:0] tag_address = '0;
	logic [3:0] slot_index = '0;
	logic [1:0] outcome = '0;
	logic cfg_valid = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic busy, result_valid, found, moving, woke, last, cfg_ready;
	logic [3:0] slot;
	logic [15:0] identity, miss_count;
	logic [11:0] battery_mv;

	// clock, 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	motion_adaptive_ranging_scheduler u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.now_ms(now_ms), .tag_address(tag_address), .slot_index(slot_index),
		.outcome(outcome), .result_valid(result_valid), .found(found), .slot(slot),
		.identity(identity), .moving(moving), .woke(woke), .battery_mv(battery_mv),
		.miss_count(miss_count), .last(last), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// scheduler shadow: configuration and per-entry state
	logic [31:0] fast_p, slow_p, hold_p, cap_p, drain_p;
	logic [4:0]  count_p;
	logic [15:0] tag_tab [ENTRIES];
	logic [31:0] served_at [ENTRIES];
	logic [31:0] motion_until [ENTRIES];
	logic [31:0] wakes [ENTRIES];
	logic [15:0] misses [ENTRIES];
	logic [31:0] charge [ENTRIES];
	bit served_ok [ENTRIES];
	bit motion_ok [ENTRIES];

	mars_pkg::mars_res_t result_q [$];
	int mismatches = 0;
	int idle_cyc = 0;
	bit allow_gaps = 1'b1;
	logic [31:0] clock_ms = '0;

	function automatic bit in_motion(int i, logic [31:0] t);
		logic [31:0] d;
		d = motion_until[i] - t;
		return motion_ok[i] && d != 32'd0 && !d[31];
	endfunction

	function automatic int entries_used();
		return (count_p > ENTRIES) ? ENTRIES : int'(count_p);
	endfunction

	// piecewise cell voltage, rounded as the block rounds
	function automatic logic [11:0] cell_mv(logic [31:0] c32);
		logic [63:0] c, cap;
		c = {32'd0, c32};
		cap = {32'd0, cap_p};
		if (c >= cap) return mars_pkg::MV_EMPTY;
		if (5 * c < 4 * cap) return 12'(64'd3000 - (375 * c + 2 * cap - 1) / (2 * cap));
		return 12'(64'd6250 - (4250 * c + cap - 1) / cap);
	endfunction

	function automatic mars_pkg::mars_res_t res_word(logic f, logic [3:0] s,
		logic [15:0] id, logic mv, logic wk, logic [11:0] bv, logic [15:0] ms, logic l);
		mars_pkg::mars_res_t r;
		r = '{found: f, slot: s, identity: id, moving: mv, woke: wk,
			battery_mv: bv, miss_count: ms, last: l};
		return r;
	endfunction

	// work out the words one accepted command produces
	task automatic schedule_words(logic [2:0] k, logic [31:0] t, logic [15:0] a,
		logic [3:0] s, logic [1:0] o);
		int n, hit, emitted;
		bit was, mv;
		logic [31:0] per;
		logic [15:0] mout;
		n = entries_used();
		hit = -1;
		emitted = 0;
		if (k == mars_pkg::KIND_LOAD) begin
			tag_tab[s] = a;
			result_q.push_back(res_word(1, s, a, 0, 0, 0, 0, 1));
		end else if (k == mars_pkg::KIND_TICK) begin
			for (int i = 0; i < n && emitted < mars_pkg::RESULT_LIMIT; i++) begin
				mv = in_motion(i, t);
				per = mv ? fast_p : slow_p;
				if (served_ok[i] && (t - served_at[i]) < per) continue;
				served_at[i] = t;
				served_ok[i] = 1;
				result_q.push_back(res_word(1, 4'(i), tag_tab[i], mv, 0, 0, 0, 0));
				emitted++;
			end
			if (emitted == 0) result_q.push_back(res_word(0, 0, 0, 0, 0, 0, 0, 1));
			else result_q[$].last = 1'b1;
		end else if (k > mars_pkg::KIND_EXCHANGE) begin
			result_q.push_back(res_word(0, 0, 0, 0, 0, 0, 0, 1));
		end else begin
			for (int i = n - 1; i >= 0; i--)
				if (tag_tab[i] == a) hit = i;
			if (hit < 0) begin
				result_q.push_back(res_word(0, 0, 0, 0, 0, 0, 0, 1));
			end else if (k == mars_pkg::KIND_MOTION) begin
				was = in_motion(hit, t);
				motion_until[hit] = t + hold_p;
				motion_ok[hit] = 1;
				if (!was) wakes[hit] = wakes[hit] + 1;
				served_ok[hit] = 0;
				served_at[hit] = '0;
				result_q.push_back(res_word(1, 4'(hit), tag_tab[hit], in_motion(hit, t),
					!was, 0, 0, 1));
			end else if (k == mars_pkg::KIND_SETTLE) begin
				motion_until[hit] = '0;
				motion_ok[hit] = 0;
				served_at[hit] = '0;
				served_ok[hit] = 0;
				result_q.push_back(res_word(1, 4'(hit), tag_tab[hit], 0, 0, 0, 0, 1));
			end else begin
				// exchange outcome: bill unless missed before, then count or clear misses
				if (o != mars_pkg::OUT_MISS_PRE)
					charge[hit] = (charge[hit] > 32'hFFFF_FFFF - drain_p) ?
						32'hFFFF_FFFF : charge[hit] + drain_p;
				if (o == mars_pkg::OUT_SUCCESS) begin
					mout = misses[hit];
					misses[hit] = '0;
				end else begin
					if (misses[hit] != mars_pkg::MISS_MAX) misses[hit]++;
					mout = misses[hit];
				end
				result_q.push_back(res_word(1, 4'(hit), tag_tab[hit], in_motion(hit, t), 0,
					cell_mv(charge[hit]), mout, 1));
			end
		end
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		mars_pkg::mars_res_t got, want;
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cyc = 0;
			else idle_cyc++;
			if (idle_cyc >= DOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else if (result_valid) begin
				got = res_word(found, slot, identity, moving, woke, battery_mv,
					miss_count, last);
				if (result_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %p", got);
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) $display("word mismatch: expected %p actual %p",
							want, got);
					end
				end
			end
		end
	end

	// one command word, then sometimes a random gap
	task automatic send(stim_row_t r);
		kind = r.k;
		now_ms = r.t;
		tag_address = r.a;
		slot_index = r.s;
		outcome = r.o;
		start = 1'b1;
		do @(posedge clk); while (busy);
		schedule_words(r.k, r.t, r.a, r.s, r.o);
		if (r.typed) begin
			void'(result_q.pop_back());
			result_q.push_back(r.want);
		end
		@(negedge clk);
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
	endtask

	// quiet the command port, drain everything, then let the block finish
	task automatic wait_idle();
		start = 1'b0;
		while (result_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		cfg_index = idx;
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			mars_pkg::REG_FAST: fast_p = (v < mars_pkg::FAST_MIN) ? mars_pkg::FAST_MIN : v;
			mars_pkg::REG_SLOW: slow_p = (v < mars_pkg::SLOW_MIN) ? mars_pkg::SLOW_MIN : v;
			mars_pkg::REG_HOLD: hold_p = v;
			mars_pkg::REG_COUNT: count_p = v[4:0];
			mars_pkg::REG_CAP: cap_p = v;
			mars_pkg::REG_DRAIN: drain_p = v;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all(logic [31:0] f, logic [31:0] sl, logic [31:0] h,
		logic [31:0] n, logic [31:0] c, logic [31:0] d);
		write_reg(mars_pkg::REG_FAST, f);
		write_reg(mars_pkg::REG_SLOW, sl);
		write_reg(mars_pkg::REG_HOLD, h);
		write_reg(mars_pkg::REG_COUNT, n);
		write_reg(mars_pkg::REG_CAP, c);
		write_reg(mars_pkg::REG_DRAIN, d);
	endtask

	function automatic stim_row_t row(logic [2:0] k, logic [31:0] t, logic [15:0] a,
		logic [3:0] s, logic [1:0] o);
		stim_row_t r;
		r = '{k: k, t: t, a: a, s: s, o: o, typed: 0, want: '0};
		return r;
	endfunction

	function automatic stim_row_t typed_row(logic [2:0] k, logic [31:0] t,
		logic [15:0] a, logic [3:0] s, mars_pkg::mars_res_t w);
		stim_row_t r;
		r = row(k, t, a, s, mars_pkg::OUT_SUCCESS);
		r.typed = 1;
		r.want = w;
		return r;
	endfunction

	// random command with a well-formed address most of the time
	function automatic stim_row_t random_row();
		logic [2:0] k;
		logic [15:0] a;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) k = mars_pkg::KIND_LOAD;
		else if (pick < 30) k = mars_pkg::KIND_MOTION;
		else if (pick < 40) k = mars_pkg::KIND_SETTLE;
		else if (pick < 65) k = mars_pkg::KIND_TICK;
		else if (pick < 96) k = mars_pkg::KIND_EXCHANGE;
		else k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
		if ($urandom_range(0, 14) == 0) clock_ms = $urandom;
		else clock_ms = clock_ms + $urandom_range(0, 2500);
		a = ($urandom_range(0, 4) == 0) ? 16'($urandom) : tag_tab[$urandom_range(0, 15)];
		return row(k, clock_ms, a, 4'($urandom), 2'($urandom));
	endfunction

	stim_row_t directed [$];

	initial begin
		fast_p = mars_pkg::FAST_RESET;
		slow_p = mars_pkg::SLOW_RESET;
		hold_p = mars_pkg::HOLD_RESET;
		count_p = mars_pkg::COUNT_RESET;
		cap_p = mars_pkg::CAP_RESET;
		drain_p = mars_pkg::DRAIN_RESET;
		for (int i = 0; i < ENTRIES; i++) begin
			tag_tab[i] = '0; served_at[i] = '0; motion_until[i] = '0; wakes[i] = '0;
			misses[i] = '0; charge[i] = '0; served_ok[i] = 0; motion_ok[i] = 0;
		end
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill every slot first so no lookup ever reads an unwritten entry
		for (int i = 0; i < ENTRIES; i++)
			send(typed_row(mars_pkg::KIND_LOAD, 32'd0, 16'(i * 16'h1111), 4'(i),
				res_word(1, 4'(i), 16'(i * 16'h1111), 0, 0, 0, 0, 1)));
		wait_idle();
		write_reg(mars_pkg::REG_COUNT, 32'd16);

		// directed: every kind but load, every outcome, time extremes
		directed.push_back(row(mars_pkg::KIND_TICK, 32'd0, 0, 0, mars_pkg::OUT_SUCCESS));
		directed.push_back(row(mars_pkg::KIND_MOTION, 32'd100, 16'h3333, 0,
			mars_pkg::OUT_SUCCESS));
		directed.push_back(row(mars_pkg::KIND_MOTION, 32'd200, 16'h3333, 0,
			mars_pkg::OUT_SUCCESS));
		directed.push_back(row(mars_pkg::KIND_TICK, 32'd1200, 0, 0, mars_pkg::OUT_SUCCESS));
		directed.push_back(row(mars_pkg::KIND_EXCHANGE, 32'd1300, 16'h3333, 0,
			mars_pkg::OUT_MISS_PRE));
		directed.push_back(row(mars_pkg::KIND_EXCHANGE, 32'd1300, 16'h3333, 0, OUT_MISS_POST));
		directed.push_back(row(mars_pkg::KIND_EXCHANGE, 32'd1400, 16'h3333, 0, OUT_MISS_ODD));
		directed.push_back(row(mars_pkg::KIND_EXCHANGE, 32'd1500, 16'h3333, 0,
			mars_pkg::OUT_SUCCESS));
		directed.push_back(row(mars_pkg::KIND_SETTLE, 32'd1600, 16'h3333, 0,
			mars_pkg::OUT_SUCCESS));
		directed.push_back(row(mars_pkg::KIND_MOTION, 32'hFFFF_FFF0, 16'hFFFF, 0,
			mars_pkg::OUT_SUCCESS));
		directed.push_back(row(mars_pkg::KIND_TICK, 32'hFFFF_FFFF, 0, 0,
			mars_pkg::OUT_SUCCESS));
		directed.push_back(typed_row(mars_pkg::KIND_MOTION, 32'd5, 16'h1234, 0,
			res_word(0, 0, 0, 0, 0, 0, 0, 1)));
		directed.push_back(typed_row(KIND_SPARE_FIRST, 32'hFFFF_FFFF, 16'hFFFF, 4'hF,
			res_word(0, 0, 0, 0, 0, 0, 0, 1)));
		directed.push_back(typed_row(KIND_SPARE_LAST, 32'd0, 16'h0000, 4'h0,
			res_word(0, 0, 0, 0, 0, 0, 0, 1)));
		directed.push_back(row(mars_pkg::KIND_EXCHANGE, 32'd0, 16'h0000, 0, OUT_MISS_POST));
		foreach (directed[i]) send(directed[i]);

		// random phases, each under its own register setting
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			case (p)
				0: write_all(32'd0, 32'd0, 32'd0, 32'd16, 32'd1, 32'd0);
				1: write_all(32'd700, 32'd2500, 32'd4000, 32'd31, 32'd5000, 32'd300);
				2: write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5,
					32'hFFFF_FFFF, 32'hFFFF_FFFF);
				3: write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd1000, 32'd50);
				default: write_all($urandom_range(500, 2000), $urandom_range(1000, 6000),
					$urandom_range(0, 8000), $urandom_range(1, 16),
					$urandom_range(1000, 100000), $urandom_range(0, 2000));
			endcase
			for (int n = 0; n < ((p == 3) ? 10 : 35); n++) begin
				if (p == 5 && n >= 20) allow_gaps = 1'b0;
				if (allow_gaps && $urandom_range(0, 24) == 0) begin
					start = 1'b0;
					while (result_q.size() != 0) @(negedge clk);
				end
				send(random_row());
			end
		end

		wait_idle();
		if (mismatches == 0 && result_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
